>>> rtl/tts_pkg.sv
// shared codes and beat payload types for the timer table scheduler
package tts_pkg;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_CANCEL  = 3'd1;
	localparam logic [2:0] OP_REFRESH = 3'd2;
	localparam logic [2:0] OP_RESET   = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;
	localparam logic [2:0] OP_WAIT    = 3'd5;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_TICK    = 2'd2;
	localparam logic [1:0] KIND_WAIT    = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] timer_id;
		logic [31:0] interval_ms;
		logic        recurring;
		logic        now_based;
		logic [15:0] elapsed_ms;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        ok;
		logic [31:0] reported_id;
		logic [31:0] wait_ms;
		logic        has_timer;
		logic        front_changed;
		logic        last;
	} rsp_t;

endpackage

>>> rtl/tts_stream_if.sv
// valid/ready stream channel carrying one payload beat
interface tts_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/timer_table_scheduler.sv
// timer table scheduler: slot table scanned one slot per cycle by a small sequencer
// add scans the table once for front placement and cancel once for the id; refresh and reset
// scan for the id, then for front placement; next-wait scans once, then forms the wait;
// a tick scans the table once per expired timer plus a final scan, as there is only
// the single slot-read port and comparator. one command at a time; cmd.ready only idle.
// reset clears valid bits, time, id counter and front flag; slot contents are not cleared
module timer_table_scheduler #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	tts_stream_if.sink   cmd,
	tts_stream_if.source rsp
);
	import tts_pkg::*;

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_FIND, S_FRONT, S_TSCAN, S_TAPPLY, S_WSCAN, S_WAIT, S_OUT
	} state_t;

	state_t state_q;

	// slot table
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [TIMER_SLOTS-1:0] done_q;
	logic [31:0]            id_q    [TIMER_SLOTS];
	logic [TIME_BITS-1:0]   exp_q   [TIMER_SLOTS];
	logic [31:0]            ival_q  [TIMER_SLOTS];
	logic                   rec_q   [TIMER_SLOTS];

	logic [TIME_BITS-1:0] now_q;
	logic [31:0]          next_id_q;
	logic                 front_q;

	// latched command
	logic [2:0]  op_q;
	logic [31:0] tid_q;
	logic [31:0] cival_q;
	logic        fnow_q;

	// scan state
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     tgt_q;
	logic [IDX_W-1:0]     best_q;
	logic                 bf_q;
	logic [TIME_BITS-1:0] best_exp_q;

	// pending result
	logic [1:0]  res_kind_q;
	logic        res_ok_q;
	logic [31:0] res_id_q;
	logic [31:0] res_wait_q;
	logic        res_front_q;
	logic        res_last_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// slot read port
	logic [IDX_W-1:0]     rd_idx;
	logic                 rd_valid;
	logic                 rd_done;
	logic [31:0]          rd_id;
	logic [TIME_BITS-1:0] rd_exp;
	logic [31:0]          rd_ival;
	logic                 rd_rec;

	always_comb begin
		rd_idx   = (state_q == S_TAPPLY) ? best_q : idx_q;
		rd_valid = valid_q[rd_idx];
		rd_done  = done_q[rd_idx];
		rd_id    = id_q[rd_idx];
		rd_exp   = exp_q[rd_idx];
		rd_ival  = ival_q[rd_idx];
		rd_rec   = rec_q[rd_idx];
	end

	// lowest free slot
	logic [IDX_W-1:0] free_idx;
	logic             free_found;

	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx   = IDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	// shared saturating adder
	logic [TIME_BITS-1:0] add_a;
	logic [TIME_BITS-1:0] add_b;
	logic [TIME_BITS:0]   add_full;
	logic [TIME_BITS-1:0] add_sum;

	always_comb begin
		add_a = now_q;
		add_b = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd.data.op == OP_TICK) begin
					add_b = TIME_BITS'(cmd.data.elapsed_ms);
				end else begin
					add_b = TIME_BITS'(cmd.data.interval_ms);
				end
			end
			S_FIND: begin
				if (op_q == OP_REFRESH) begin
					add_b = TIME_BITS'(rd_ival);
				end else begin
					add_b = TIME_BITS'(cival_q);
					if (!fnow_q) add_a = rd_exp;
				end
			end
			S_TAPPLY: begin
				add_b = (rd_ival == '0) ? TIME_BITS'(1) : TIME_BITS'(rd_ival);
			end
			default: begin
				add_b = '0;
			end
		endcase
		add_full = {1'b0, add_a} + {1'b0, add_b};
		add_sum  = add_full[TIME_BITS] ? '1 : add_full[TIME_BITS-1:0];
	end

	// per-slot comparisons
	logic idx_at_last;
	logic id_hit;
	logic front_fail;
	logic tick_cand;
	logic wait_cand;

	always_comb begin
		idx_at_last = (idx_q == IDX_LAST);
		id_hit      = rd_valid && (rd_id == tid_q);
		front_fail  = (idx_q != tgt_q) && rd_valid && (rd_exp <= best_exp_q);
		tick_cand   = rd_valid && !rd_done && (rd_exp <= now_q) &&
			(!bf_q || (rd_exp < best_exp_q));
		wait_cand   = rd_valid && (!bf_q || (rd_exp < best_exp_q));
	end

	// wait time from earliest expiry
	logic [TIME_BITS-1:0] diff;
	logic [63:0]          diff64;
	logic [31:0]          wait_val;

	always_comb begin
		diff   = best_exp_q - now_q;
		diff64 = 64'(diff);
		if (best_exp_q <= now_q) begin
			wait_val = '0;
		end else if (|diff64[63:32]) begin
			wait_val = '1;
		end else begin
			wait_val = diff64[31:0];
		end
	end

	// slot payload storage
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.valid && cmd.data.op == OP_ADD && free_found) begin
			id_q[free_idx]   <= next_id_q + 32'd1;
			ival_q[free_idx] <= cmd.data.interval_ms;
			rec_q[free_idx]  <= cmd.data.recurring;
			exp_q[free_idx]  <= add_sum;
		end else if (state_q == S_FIND && id_hit && op_q != OP_CANCEL) begin
			exp_q[idx_q] <= add_sum;
		end else if (state_q == S_TAPPLY && rd_rec) begin
			exp_q[best_q] <= add_sum;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			done_q      <= '0;
			now_q       <= '0;
			next_id_q   <= '0;
			front_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			bf_q        <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_OUT) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q        <= cmd.data.op;
						tid_q       <= cmd.data.timer_id;
						cival_q     <= cmd.data.interval_ms;
						fnow_q      <= cmd.data.now_based;
						idx_q       <= '0;
						bf_q        <= 1'b0;
						res_kind_q  <= KIND_ACK;
						res_ok_q    <= 1'b0;
						res_id_q    <= '0;
						res_wait_q  <= '0;
						res_front_q <= 1'b0;
						res_last_q  <= 1'b1;
						case (cmd.data.op)
							OP_ADD: begin
								if (free_found) begin
									valid_q[free_idx] <= 1'b1;
									next_id_q         <= next_id_q + 32'd1;
									tgt_q             <= free_idx;
									best_exp_q        <= add_sum;
									res_ok_q          <= 1'b1;
									res_id_q          <= next_id_q + 32'd1;
									state_q           <= S_FRONT;
								end else begin
									state_q <= S_OUT;
								end
							end
							OP_CANCEL, OP_REFRESH, OP_RESET: begin
								state_q <= S_FIND;
							end
							OP_TICK: begin
								now_q   <= add_sum;
								done_q  <= '0;
								state_q <= S_TSCAN;
							end
							OP_WAIT: begin
								front_q <= 1'b0;
								state_q <= S_WSCAN;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_FIND: begin
					if (id_hit) begin
						res_ok_q <= 1'b1;
						if (op_q == OP_CANCEL) begin
							valid_q[idx_q] <= 1'b0;
							state_q        <= S_OUT;
						end else begin
							tgt_q      <= idx_q;
							best_exp_q <= add_sum;
							idx_q      <= '0;
							state_q    <= S_FRONT;
						end
					end else if (idx_at_last) begin
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_FRONT: begin
					if (front_fail) begin
						state_q <= S_OUT;
					end else if (idx_at_last) begin
						res_front_q <= !front_q;
						front_q     <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_TSCAN: begin
					if (tick_cand) begin
						bf_q       <= 1'b1;
						best_q     <= idx_q;
						best_exp_q <= rd_exp;
					end
					if (idx_at_last) begin
						if (bf_q || tick_cand) begin
							state_q <= S_TAPPLY;
						end else begin
							res_kind_q <= KIND_TICK;
							res_ok_q   <= 1'b1;
							res_id_q   <= '0;
							res_last_q <= 1'b1;
							state_q    <= S_OUT;
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_TAPPLY: begin
					done_q[best_q] <= 1'b1;
					if (!rd_rec) valid_q[best_q] <= 1'b0;
					res_kind_q <= KIND_EXPIRED;
					res_ok_q   <= 1'b1;
					res_id_q   <= rd_id;
					res_last_q <= 1'b0;
					state_q    <= S_OUT;
				end
				S_WSCAN: begin
					if (wait_cand) begin
						bf_q       <= 1'b1;
						best_exp_q <= rd_exp;
					end
					if (idx_at_last) begin
						state_q <= S_WAIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_WAIT: begin
					res_kind_q <= KIND_WAIT;
					res_ok_q   <= bf_q;
					res_wait_q <= bf_q ? wait_val : '1;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.kind          <= res_kind_q;
						rsp_q.ok            <= res_ok_q;
						rsp_q.reported_id   <= res_id_q;
						rsp_q.wait_ms       <= res_wait_q;
						rsp_q.has_timer     <= |valid_q;
						rsp_q.front_changed <= res_front_q;
						rsp_q.last          <= res_last_q;
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= '0;
							bf_q    <= 1'b0;
							state_q <= S_TSCAN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> test/timer_table_scheduler_tb.sv
// self-checking testbench for the timer table scheduler
module timer_table_scheduler_tb;
	import tts_pkg::*;

	localparam int SLOTS = 16;
	localparam int TBITS = 48;
	localparam logic [TBITS-1:0] TIME_MAX = {TBITS{1'b1}};
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;

	tts_stream_if #(.payload_t(cmd_t)) cmd_ch ();
	tts_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	timer_table_scheduler #(.TIMER_SLOTS(SLOTS), .TIME_BITS(TBITS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// predicted scheduler state
	logic             tbl_valid [SLOTS];
	logic [31:0]      tbl_id [SLOTS];
	logic [TBITS-1:0] tbl_expiry [SLOTS];
	logic [31:0]      tbl_interval [SLOTS];
	logic             tbl_recurring [SLOTS];
	logic [TBITS-1:0] now_ms;
	logic [31:0]      id_counter;
	logic             front_seen;

	rsp_t pending_rsp [$];
	int   mismatches;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   quiet_cycles;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [TBITS-1:0] time_add(logic [TBITS-1:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {17'd0, a} + {1'b0, b};
		return (s > {17'd0, TIME_MAX}) ? TIME_MAX : s[TBITS-1:0];
	endfunction

	function automatic logic table_busy();
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic int slot_of(logic [31:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic logic claim_front(int s);
		for (int i = 0; i < SLOTS; i++)
			if (i != s && tbl_valid[i] && tbl_expiry[i] <= tbl_expiry[s])
				return 1'b0;
		if (front_seen)
			return 1'b0;
		front_seen = 1'b1;
		return 1'b1;
	endfunction

	function automatic void push_rsp(logic [1:0] kind, logic ok, logic [31:0] id,
			logic [31:0] wait_v, logic front, logic fin);
		rsp_t r;
		r.kind = kind;
		r.ok = ok;
		r.reported_id = id;
		r.wait_ms = wait_v;
		r.has_timer = table_busy();
		r.front_changed = front;
		r.last = fin;
		pending_rsp = {pending_rsp, r};
	endfunction

	// predict the responses of one command beat
	function automatic void predict_timers(cmd_t c);
		int s;
		int best;
		logic fc;
		logic done [SLOTS];
		logic [63:0] w;
		logic [31:0] iv;
		fc = 1'b0;
		case (c.op)
			OP_ADD: begin
				s = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!tbl_valid[i])
						s = i;
				if (s < 0) begin
					push_rsp(KIND_ACK, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1);
				end else begin
					id_counter = id_counter + 32'd1;
					tbl_valid[s] = 1'b1;
					tbl_id[s] = id_counter;
					tbl_interval[s] = c.interval_ms;
					tbl_recurring[s] = c.recurring;
					tbl_expiry[s] = time_add(now_ms, {32'd0, c.interval_ms});
					fc = claim_front(s);
					push_rsp(KIND_ACK, 1'b1, id_counter, 32'd0, fc, 1'b1);
				end
			end
			OP_CANCEL: begin
				s = slot_of(c.timer_id);
				if (s >= 0)
					tbl_valid[s] = 1'b0;
				push_rsp(KIND_ACK, s >= 0, 32'd0, 32'd0, 1'b0, 1'b1);
			end
			OP_REFRESH, OP_RESET: begin
				s = slot_of(c.timer_id);
				if (s >= 0) begin
					if (c.op == OP_REFRESH)
						tbl_expiry[s] = time_add(now_ms, {32'd0, tbl_interval[s]});
					else if (c.now_based)
						tbl_expiry[s] = time_add(now_ms, {32'd0, c.interval_ms});
					else
						tbl_expiry[s] = time_add(tbl_expiry[s], {32'd0, c.interval_ms});
					fc = claim_front(s);
				end
				push_rsp(KIND_ACK, s >= 0, 32'd0, 32'd0, fc, 1'b1);
			end
			OP_TICK: begin
				for (int i = 0; i < SLOTS; i++)
					done[i] = 1'b0;
				now_ms = time_add(now_ms, {48'd0, c.elapsed_ms});
				forever begin
					best = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (!tbl_valid[i] || done[i] || tbl_expiry[i] > now_ms)
							continue;
						if (best < 0 || tbl_expiry[i] < tbl_expiry[best])
							best = i;
					end
					if (best < 0)
						break;
					done[best] = 1'b1;
					if (tbl_recurring[best]) begin
						iv = (tbl_interval[best] != 0) ? tbl_interval[best] : 32'd1;
						tbl_expiry[best] = time_add(now_ms, {32'd0, iv});
					end else begin
						tbl_valid[best] = 1'b0;
					end
					push_rsp(KIND_EXPIRED, 1'b1, tbl_id[best], 32'd0, 1'b0, 1'b0);
				end
				push_rsp(KIND_TICK, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1);
			end
			OP_WAIT: begin
				best = -1;
				front_seen = 1'b0;
				for (int i = 0; i < SLOTS; i++)
					if (tbl_valid[i] && (best < 0 || tbl_expiry[i] < tbl_expiry[best]))
						best = i;
				if (best < 0) begin
					push_rsp(KIND_WAIT, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
				end else begin
					w = 64'd0;
					if (tbl_expiry[best] > now_ms) begin
						w = {16'd0, tbl_expiry[best] - now_ms};
						if (w > 64'hFFFF_FFFF)
							w = 64'hFFFF_FFFF;
					end
					push_rsp(KIND_WAIT, 1'b1, 32'd0, w[31:0], 1'b0, 1'b1);
				end
			end
			default: push_rsp(KIND_ACK, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	// send one command beat with optional idle gaps
	task automatic send_cmd(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		predict_timers(c);
	endtask

	function automatic cmd_t make_cmd(logic [2:0] op, logic [31:0] id, logic [31:0] iv,
			logic rec, logic fnow, logic [15:0] el);
		cmd_t c;
		c.op = op;
		c.timer_id = id;
		c.interval_ms = iv;
		c.recurring = rec;
		c.now_based = fnow;
		c.elapsed_ms = el;
		return c;
	endfunction

	// response ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected beat", 32'd0, 32'd0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.data.kind != want.kind)
					report_mismatch("kind", 32'(rsp_ch.data.kind), 32'(want.kind));
				if (rsp_ch.data.ok != want.ok)
					report_mismatch("ok", 32'(rsp_ch.data.ok), 32'(want.ok));
				if (rsp_ch.data.reported_id != want.reported_id)
					report_mismatch("reported_id", rsp_ch.data.reported_id, want.reported_id);
				if (rsp_ch.data.wait_ms != want.wait_ms)
					report_mismatch("wait_ms", rsp_ch.data.wait_ms, want.wait_ms);
				if (rsp_ch.data.has_timer != want.has_timer)
					report_mismatch("has_timer", 32'(rsp_ch.data.has_timer),
						32'(want.has_timer));
				if (rsp_ch.data.front_changed != want.front_changed)
					report_mismatch("front_changed", 32'(rsp_ch.data.front_changed),
						32'(want.front_changed));
				if (rsp_ch.data.last != want.last)
					report_mismatch("last", 32'(rsp_ch.data.last), 32'(want.last));
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** timer_table_scheduler: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] pick_id();
		int k;
		k = $urandom_range(SLOTS - 1);
		if ($urandom_range(9) == 0 || !tbl_valid[k])
			return $urandom_range(9) == 0 ? $urandom() : id_counter - $urandom_range(3);
		return tbl_id[k];
	endfunction

	function automatic logic [31:0] pick_interval();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			default: return $urandom_range(200);
		endcase
	endfunction

	// directed: extremes, every op and special cases
	task automatic test_directed();
		send_cmd(make_cmd(OP_WAIT, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_CANCEL, 32'd5, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_ADD, 0, 32'd10, 1'b0, 0, 0));
		send_cmd(make_cmd(OP_ADD, 0, 32'd10, 1'b1, 0, 0));
		send_cmd(make_cmd(OP_ADD, 0, 32'd0, 1'b1, 0, 0));
		send_cmd(make_cmd(OP_ADD, 0, 32'hFFFF_FFFF, 1'b0, 0, 0));
		send_cmd(make_cmd(OP_WAIT, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_REFRESH, 32'd2, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_RESET, 32'd1, 32'd3, 0, 1'b1, 0));
		send_cmd(make_cmd(OP_RESET, 32'd4, 32'hFFFF_FFFF, 0, 1'b0, 0));
		send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 16'd0));
		send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 16'd15));
		send_cmd(make_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF));
		send_cmd(make_cmd(3'd7, 0, 0, 0, 0, 0));
		// fill the table to the full case
		for (int i = 0; i < SLOTS; i++)
			send_cmd(make_cmd(OP_ADD, $urandom(), $urandom_range(50), 1'b1, 1'b1, 0));
		send_cmd(make_cmd(OP_WAIT, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 16'hFFFF));
	endtask

	// random: mostly well-formed operations on live ids
	task automatic test_random(int count);
		logic [2:0] op;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4: op = OP_ADD;
				5, 6: op = OP_CANCEL;
				7, 8: op = OP_REFRESH;
				9, 10: op = OP_RESET;
				11, 12, 13, 14: op = OP_TICK;
				15, 16, 17: op = OP_WAIT;
				default: op = 3'($urandom_range(7));
			endcase
			send_cmd(make_cmd(op, pick_id(), pick_interval(), 1'($urandom()),
				1'($urandom()), $urandom_range(9) == 0 ? 16'($urandom()) :
				16'($urandom_range(60))));
		end
	endtask

	// cancel a few live or stale ids, then a long tick
	task automatic test_id_wrap();
		for (int i = 0; i < 6; i++)
			send_cmd(make_cmd(OP_CANCEL, pick_id(), 0, 0, 0, 0));
		send_cmd(make_cmd(OP_TICK, 0, 0, 0, 0, 16'hFFFF));
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SLOTS * 4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 32;
		recv_idle_pct = 56;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_id[i] = '0;
			tbl_expiry[i] = '0;
			tbl_interval[i] = '0;
			tbl_recurring[i] = 1'b0;
		end
		now_ms = '0;
		id_counter = '0;
		front_seen = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(130);
		send_idle_pct = 56;
		recv_idle_pct = 32;
		test_random(130);
		test_id_wrap();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(130);
		drain();
		if (mismatches == 0)
			$display("** timer_table_scheduler: PASSED **");
		else
			$display("** timer_table_scheduler: FAILED **");
		$finish;
	end

endmodule
